/* hdl/tle_pkg.sv */
// Shared types, character codes and the echo sequence table for the terminal line editor.
`default_nettype none

package tle_pkg;

	// Field widths of the request and result channels.
	localparam int BYTE_W = 8;
	localparam int KIND_W = 2;

	// Received characters with a meaning of their own.
	localparam logic [BYTE_W-1:0] CHR_CR    = 8'h0d;
	localparam logic [BYTE_W-1:0] CHR_ESC   = 8'h1b;
	localparam logic [BYTE_W-1:0] CHR_BS    = 8'h08;
	localparam logic [BYTE_W-1:0] CHR_LBRK  = 8'h5b;
	localparam logic [BYTE_W-1:0] CHR_LEFT  = 8'h44;
	localparam logic [BYTE_W-1:0] CHR_UP    = 8'h41;
	localparam logic [BYTE_W-1:0] CHR_DOWN  = 8'h42;
	localparam logic [BYTE_W-1:0] CHR_RIGHT = 8'h43;
	localparam logic [BYTE_W-1:0] CHR_SPACE = 8'h20;

	// Result kinds.
	localparam logic [KIND_W-1:0] KIND_ECHO  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LINE  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

	// Echo sequence indexes: cursor left is entries 0..2, backspace is 0..6.
	localparam int SEQ_W = 3;
	localparam logic [SEQ_W-1:0] SEQ_LEFT_END = 3'd2;
	localparam logic [SEQ_W-1:0] SEQ_BS_END   = 3'd6;

	// Escape decoder state.
	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_ESC    = 2'd1,
		MODE_CSI    = 2'd2
	} mode_t;

	// What a request needs from the result side.
	typedef enum logic [2:0] {
		ACT_NONE  = 3'd0,
		ACT_ECHO  = 3'd1,
		ACT_EMPTY = 3'd2,
		ACT_LEFT  = 3'd3,
		ACT_BS    = 3'd4,
		ACT_LINE  = 3'd5
	} act_t;

	// Source of the next result loaded into the output register.
	typedef enum logic [1:0] {
		SRC_PEND = 2'd0,
		SRC_SEQ  = 2'd1,
		SRC_RAM  = 2'd2
	} src_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;
		logic load;
		src_t src;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		act_t act;
		logic slot_free;
		logic seq_last;
		logic rd_last;
	} sts_t;

	// Byte of the cursor-left / erase echo sequence at a given index.
	function automatic logic [BYTE_W-1:0] echo_byte(input logic [SEQ_W-1:0] idx);
		logic [BYTE_W-1:0] b;
		unique case (idx)
			3'd0, 3'd4: b = CHR_ESC;
			3'd1, 3'd5: b = CHR_LBRK;
			3'd2, 3'd6: b = CHR_LEFT;
			3'd3:       b = CHR_SPACE;
			default:    b = CHR_ESC;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

/* hdl/terminal_line_editor_unit.sv */
// Top level of the terminal line editor: controller, datapath and line store.
//
//  Channel   Signals                        Direction  Handshake
//  request   rx_byte                        in         in_valid / in_stall
//  result    kind, data, last               out        out_valid / out_stall
//
// An ordinary byte is taken and its echo is then loaded into the output register
// once the output slot is free. Cursor left gives three results, backspace seven,
// one a cycle from the echo sequence counter while the output is not stalled.
// A carriage return hands out N line bytes via the line store's registered read port.
// Reset clears the cursor, line length, escape state and output; the line store
// is not cleared. An output stall holds the result and pauses the sequencer.
`default_nettype none

module terminal_line_editor_unit
	import tle_pkg::*;
#(
	parameter int LINE_DEPTH = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [BYTE_W-1:0] rx_byte,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic      [KIND_W-1:0] kind,
	output logic      [BYTE_W-1:0] data,
	output logic                   last
);

	cmd_t cmd;
	sts_t sts;

	tle_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	tle_dp #(
		.LINE_DEPTH(LINE_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_byte  (rx_byte),
		.cmd      (cmd),
		.sts      (sts),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind     (kind),
		.data     (data),
		.last     (last)
	);

endmodule

`default_nettype wire

/* hdl/tle_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module tle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* hdl/tle_ctrl.sv */
// Controller state machine: accepts requests and sequences their results.
`default_nettype none

module tle_ctrl
	import tle_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EMIT = 4'b0010,
		ST_SEQ  = 4'b0100,
		ST_READ = 4'b1000
	} state_t;

	state_t state_q, state_d;

	// A new request is taken only while no result of the previous one is left to load.
	assign in_stall = (state_q != ST_IDLE);

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd.take = 1'b0;
		cmd.load = 1'b0;
		cmd.src  = SRC_PEND;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					unique case (sts.act)
						ACT_ECHO, ACT_EMPTY: state_d = ST_EMIT;
						ACT_LEFT, ACT_BS:    state_d = ST_SEQ;
						ACT_LINE:            state_d = ST_READ;
						default:             state_d = ST_IDLE;
					endcase
				end
			end
			ST_EMIT: begin
				cmd.src = SRC_PEND;
				if (sts.slot_free) begin
					cmd.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_SEQ: begin
				cmd.src = SRC_SEQ;
				if (sts.slot_free) begin
					cmd.load = 1'b1;
					if (sts.seq_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_READ: begin
				cmd.src = SRC_RAM;
				if (sts.slot_free) begin
					cmd.load = 1'b1;
					if (sts.rd_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

/* hdl/tle_dp.sv */
// Datapath: editing state, request decoder, line store and output register.
`default_nettype none

module tle_dp
	import tle_pkg::*;
#(
	parameter int LINE_DEPTH = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [BYTE_W-1:0] rx_byte,
	input  wire cmd_t              cmd,
	output sts_t                   sts,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic      [KIND_W-1:0] kind,
	output logic      [BYTE_W-1:0] data,
	output logic                   last
);

	localparam int AW = $clog2(LINE_DEPTH);
	localparam logic [AW-1:0] CUR_MAX = AW'(LINE_DEPTH - 1);

	mode_t             mode_q, mode_d;
	logic [AW-1:0]     cursor_q, cursor_d, cursor_inc;
	logic [AW-1:0]     length_q, length_d;
	logic [AW-1:0]     rd_q, end_q, raddr;
	logic [SEQ_W-1:0]  seq_q;
	logic              bs_q;
	logic [KIND_W-1:0] pend_kind_q;
	logic [BYTE_W-1:0] pend_data_q;
	logic [BYTE_W-1:0] ram_rdata;
	logic              wr_en;
	logic              out_valid_q;
	logic [KIND_W-1:0] kind_q;
	logic [BYTE_W-1:0] data_q;
	logic              last_q;
	logic              load_ram;
	act_t              act;

	assign cursor_inc = cursor_q + 1'b1;

	// Decode the offered byte against the current editing state.
	always_comb begin
		cursor_d = cursor_q;
		length_d = length_q;
		mode_d   = mode_q;
		act      = ACT_NONE;
		wr_en    = 1'b0;
		if (rx_byte == CHR_CR) begin
			act      = (length_q == '0) ? ACT_EMPTY : ACT_LINE;
			cursor_d = '0;
			length_d = '0;
			mode_d   = MODE_NORMAL;
		end else if (mode_q == MODE_ESC) begin
			if (rx_byte == CHR_LBRK) begin
				mode_d = MODE_CSI;
			end else begin
				cursor_d = '0;
				length_d = '0;
				mode_d   = MODE_NORMAL;
			end
		end else if (mode_q == MODE_CSI) begin
			mode_d = MODE_NORMAL;
			if (rx_byte == CHR_LEFT) begin
				if (cursor_q != '0) begin
					cursor_d = cursor_q - 1'b1;
					act      = ACT_LEFT;
				end
			end else if (rx_byte != CHR_UP && rx_byte != CHR_DOWN &&
				rx_byte != CHR_RIGHT) begin
				cursor_d = '0;
				length_d = '0;
			end
		end else begin
			mode_d = MODE_NORMAL;
			if (rx_byte == CHR_ESC) begin
				mode_d = MODE_ESC;
			end else if (rx_byte == CHR_BS) begin
				if (cursor_q != '0) begin
					cursor_d = cursor_q - 1'b1;
					if (length_q != '0) begin
						length_d = length_q - 1'b1;
					end
					act = ACT_BS;
				end
			end else begin
				// Ordinary byte: store it; a full line is dropped without echo.
				wr_en = 1'b1;
				if (cursor_q == CUR_MAX) begin
					cursor_d = '0;
					length_d = '0;
				end else begin
					cursor_d = cursor_inc;
					if (cursor_inc > length_q) begin
						length_d = cursor_inc;
					end
					act = ACT_ECHO;
				end
			end
		end
	end

	// Editing state, updated when a request is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_NORMAL;
			cursor_q <= '0;
			length_q <= '0;
		end else if (cmd.take) begin
			mode_q   <= mode_d;
			cursor_q <= cursor_d;
			length_q <= length_d;
		end
	end

	// Per-request result context and sequence counters.
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			pend_kind_q <= (act == ACT_EMPTY) ? KIND_EMPTY : KIND_ECHO;
			pend_data_q <= (act == ACT_EMPTY) ? '0 : rx_byte;
			end_q       <= length_q - 1'b1;
			bs_q        <= (act == ACT_BS);
			seq_q       <= '0;
			rd_q        <= '0;
		end else if (cmd.load) begin
			if (cmd.src == SRC_SEQ) begin
				seq_q <= seq_q + 1'b1;
			end
			if (cmd.src == SRC_RAM) begin
				rd_q <= rd_q + 1'b1;
			end
		end
	end

	// Read address runs one step ahead so the registered read keeps pace.
	assign load_ram = cmd.load && (cmd.src == SRC_RAM);
	always_comb begin
		if (cmd.take) begin
			raddr = '0;
		end else if (load_ram) begin
			raddr = rd_q + 1'b1;
		end else begin
			raddr = rd_q;
		end
	end

	tle_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(LINE_DEPTH)
	) u_line_ram (
		.clk  (clk),
		.we   (cmd.take && wr_en),
		.waddr(cursor_q),
		.wdata(rx_byte),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			unique case (cmd.src)
				SRC_SEQ: begin
					kind_q <= KIND_ECHO;
					data_q <= echo_byte(seq_q);
					last_q <= (seq_q == (bs_q ? SEQ_BS_END : SEQ_LEFT_END));
				end
				SRC_RAM: begin
					kind_q <= KIND_LINE;
					data_q <= ram_rdata;
					last_q <= (rd_q == end_q);
				end
				default: begin
					kind_q <= pend_kind_q;
					data_q <= pend_data_q;
					last_q <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign data      = data_q;
	assign last      = last_q;

	// Status to the controller.
	assign sts.act       = act;
	assign sts.slot_free = !out_valid_q || !out_stall;
	assign sts.seq_last  = (seq_q == (bs_q ? SEQ_BS_END : SEQ_LEFT_END));
	assign sts.rd_last   = (rd_q == end_q);

endmodule

`default_nettype wire

/* hdl/tle_checker.sv */
// Port-level checks for the terminal line editor and their binding to the top level.
`default_nettype none

module tle_checker
	import tle_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_stall,
	input wire logic [BYTE_W-1:0] rx_byte,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire logic [KIND_W-1:0] kind,
	input wire logic [BYTE_W-1:0] data,
	input wire logic              last
);

	// A stalled result stays in place.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(data) &&
		$stable(last))
		else $error("result changed while stalled");

	// The empty-line marker is a single result with zero data.
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_EMPTY |-> last && data == '0)
		else $error("empty-line marker malformed");

	// A carriage return always produces results, so intake pauses after it.
	a_cr_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && rx_byte == CHR_CR |=> in_stall)
		else $error("intake not paused after carriage return");

	// Every valid result carries one of the three defined kinds.
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> kind == KIND_ECHO || kind == KIND_LINE || kind == KIND_EMPTY)
		else $error("undefined result kind");

endmodule

bind terminal_line_editor_unit tle_checker u_tle_checker (.*);

`default_nettype wire
